// ===== hdl/usc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the UTF-8 script classifier: byte and result types, decode
// constants, script range limits and the script priority function. No dependencies.
package usc_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [2:0]  kind_t;
  typedef logic [1:0]  pending_t;
  typedef logic [20:0] codepoint_t;

  typedef struct packed {
    logic hangul;
    logic cjk;
    logic japanese;
    logic grcy;
  } flags_t;

  localparam kind_t KIND_LATIN    = 3'd0;
  localparam kind_t KIND_GRCY     = 3'd1;
  localparam kind_t KIND_JAPANESE = 3'd2;
  localparam kind_t KIND_CJK      = 3'd3;
  localparam kind_t KIND_HANGUL   = 3'd4;

  localparam byte_t CONT_MASK = 8'hC0;
  localparam byte_t CONT_TAG  = 8'h80;

  localparam codepoint_t HANGUL_LO   = 21'h00AC00;
  localparam codepoint_t HANGUL_HI   = 21'h00D7A3;
  localparam codepoint_t CJK_LO      = 21'h004E00;
  localparam codepoint_t CJK_HI      = 21'h009FEF;
  localparam codepoint_t CJKB_LO     = 21'h020000;
  localparam codepoint_t CJKB_HI     = 21'h0200CC;
  localparam codepoint_t JAPANESE_LO = 21'h003000;
  localparam codepoint_t JAPANESE_HI = 21'h0030FF;
  localparam codepoint_t GRCY_LO     = 21'h000370;
  localparam codepoint_t GRCY_HI     = 21'h0004FF;

  function automatic kind_t pick_kind(input flags_t flags);
    kind_t kind;
    if (flags.hangul) begin
      kind = KIND_HANGUL;
    end else if (flags.cjk) begin
      kind = KIND_CJK;
    end else if (flags.japanese) begin
      kind = KIND_JAPANESE;
    end else if (flags.grcy) begin
      kind = KIND_GRCY;
    end else begin
      kind = KIND_LATIN;
    end
    return kind;
  endfunction

endpackage

// ===== hdl/usc_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the text byte stream and the script result.
// Depends on usc_pkg for the payload types.
interface usc_byte_if;
  import usc_pkg::*;

  logic  valid;
  logic  ready;
  byte_t text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface usc_kind_if;
  import usc_pkg::*;

  logic  valid;
  logic  ready;
  kind_t script_kind;

  modport source (output valid, output script_kind, input ready);
  modport sink (input valid, input script_kind, output ready);
endinterface

// ===== hdl/usc_in_stage.sv =====
`timescale 1ns / 1ps
// Input register of the UTF-8 script classifier: holds one text byte beat.
// Depends on usc_pkg and usc_byte_if.
module usc_in_stage (
  input  logic          clk,
  input  logic          rst,
  usc_byte_if.sink      text,
  input  logic          take,
  output logic          held,
  output usc_pkg::byte_t held_byte
);
  import usc_pkg::*;

  assign text.ready = !held || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (text.ready) begin
      held <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.ready && text.valid) begin
      held_byte <= text.text_byte;
    end
  end

endmodule

// ===== hdl/usc_decoder.sv =====
`timescale 1ns / 1ps
// UTF-8 decode state and sticky script flags; one byte is consumed per step.
// Depends on usc_pkg.
module usc_decoder (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  usc_pkg::byte_t  text_byte,
  output usc_pkg::kind_t  script_kind
);
  import usc_pkg::*;

  pending_t   bytes_pending, bytes_pending_next;
  codepoint_t partial_codepoint, partial_codepoint_next;
  flags_t     flags, flags_next;
  codepoint_t cp;
  logic       is_cont;
  logic       done;

  assign is_cont = (text_byte & CONT_MASK) == CONT_TAG;
  assign cp = {partial_codepoint[14:0], text_byte[5:0]};
  assign done = (bytes_pending == 2'd1) && is_cont;
  assign script_kind = pick_kind(flags);

  always_comb begin
    bytes_pending_next = bytes_pending;
    partial_codepoint_next = partial_codepoint;
    flags_next = flags;
    if (text_byte == 8'h00) begin
      bytes_pending_next = '0;
      partial_codepoint_next = '0;
      flags_next = '0;
    end else if (bytes_pending != 2'd0 && is_cont) begin
      bytes_pending_next = bytes_pending - 2'd1;
      if (done) begin
        partial_codepoint_next = '0;
        if (cp >= HANGUL_LO && cp <= HANGUL_HI) flags_next.hangul = 1'b1;
        if ((cp >= CJK_LO && cp <= CJK_HI) || (cp >= CJKB_LO && cp <= CJKB_HI)) begin
          flags_next.cjk = 1'b1;
        end
        if (cp >= JAPANESE_LO && cp <= JAPANESE_HI) flags_next.japanese = 1'b1;
        if (cp >= GRCY_LO && cp <= GRCY_HI) flags_next.grcy = 1'b1;
      end else begin
        partial_codepoint_next = cp;
      end
    end else begin
      // A byte that is not a continuation starts a new sequence. Plain ASCII
      // never falls in a tracked script range.
      bytes_pending_next = '0;
      partial_codepoint_next = '0;
      if (text_byte[7:5] == 3'b110) begin
        bytes_pending_next = 2'd1;
        partial_codepoint_next = {16'd0, text_byte[4:0]};
      end else if (text_byte[7:4] == 4'b1110) begin
        bytes_pending_next = 2'd2;
        partial_codepoint_next = {17'd0, text_byte[3:0]};
      end else if (text_byte[7:3] == 5'b11110) begin
        bytes_pending_next = 2'd3;
        partial_codepoint_next = {18'd0, text_byte[2:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= '0;
      partial_codepoint <= '0;
      flags <= '0;
    end else if (step) begin
      bytes_pending <= bytes_pending_next;
      partial_codepoint <= partial_codepoint_next;
      flags <= flags_next;
    end
  end

endmodule

// ===== hdl/utf8_script_classifier.sv =====
`timescale 1ns / 1ps
// Top level of the UTF-8 script classifier: input register, decoder, result register.
// Depends on usc_pkg, usc_if, usc_in_stage and usc_decoder.
//
// Text arrives one byte per beat on the text channel and a zero byte closes
// the string, producing one beat on the kind channel that gives the highest-priority
// script seen (Hangul, CJK, Japanese, Greek/Cyrillic, otherwise Latin) and clearing
// all decode state. A bad lead byte, a broken sequence or a sequence left open
// at the end never sets a script flag; overlong forms are not rejected.
// The block takes one byte every cycle when not stalled. Each byte waits in the
// input register until taken, and the decoder updates its state as it is taken;
// a result is loaded into the result register as its zero byte is taken. Only a
// zero byte can stall, and only while the previous result waits to be taken.
module utf8_script_classifier (
  input logic        clk,
  input logic        rst,
  usc_byte_if.sink   text,
  usc_kind_if.source kind
);
  import usc_pkg::*;

  logic  held;
  byte_t held_byte;
  logic  is_end;
  logic  take;
  kind_t script_kind;

  assign is_end = held_byte == 8'h00;
  assign take = held && (!is_end || !kind.valid || kind.ready);

  usc_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .text      (text),
    .take      (take),
    .held      (held),
    .held_byte (held_byte)
  );

  usc_decoder u_decoder (
    .clk         (clk),
    .rst         (rst),
    .step        (take),
    .text_byte   (held_byte),
    .script_kind (script_kind)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      kind.valid <= 1'b0;
    end else if (take && is_end) begin
      kind.valid <= 1'b1;
    end else if (kind.ready) begin
      kind.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && is_end) begin
      kind.script_kind <= script_kind;
    end
  end

endmodule

// ===== dv/utf8_script_classifier_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for utf8_script_classifier: directed strings, then random UTF-8 text
// under several sender and receiver idling phases. Depends on usc_pkg, usc_if and the RTL.
module utf8_script_classifier_test;
  import usc_pkg::*;

  typedef struct {
    byte_t b;
    bit    typed;
    kind_t kind;
  } text_row_t;

  logic clk = 1'b0;
  logic rst;

  usc_byte_if text_ch ();
  usc_kind_if kind_ch ();

  utf8_script_classifier DUT (
    .clk  (clk),
    .rst  (rst),
    .text (text_ch),
    .kind (kind_ch)
  );

  pending_t    cont_left;
  codepoint_t  cp_acc;
  flags_t      seen;
  kind_t       kind_expect_q[$];
  int unsigned errors;
  int unsigned bytes_sent;
  int unsigned gap_pct;
  int unsigned stall_pct;

  text_row_t text_rows [0:25] = '{
    '{8'h00, 1'b1, KIND_LATIN},
    '{8'h41, 1'b0, KIND_LATIN},
    '{8'h7F, 1'b0, KIND_LATIN},
    '{8'h00, 1'b1, KIND_LATIN},
    '{8'hCD, 1'b0, KIND_LATIN},
    '{8'hB0, 1'b0, KIND_LATIN},
    '{8'h00, 1'b1, KIND_GRCY},
    '{8'hED, 1'b0, KIND_LATIN},
    '{8'h9E, 1'b0, KIND_LATIN},
    '{8'hA3, 1'b0, KIND_LATIN},
    '{8'hE4, 1'b0, KIND_LATIN},
    '{8'hB8, 1'b0, KIND_LATIN},
    '{8'h80, 1'b0, KIND_LATIN},
    '{8'h00, 1'b1, KIND_HANGUL},
    '{8'h80, 1'b0, KIND_LATIN},
    '{8'hFF, 1'b0, KIND_LATIN},
    '{8'hE3, 1'b0, KIND_LATIN},
    '{8'h81, 1'b0, KIND_LATIN},
    '{8'h41, 1'b0, KIND_LATIN},
    '{8'h00, 1'b1, KIND_LATIN},
    '{8'hF0, 1'b0, KIND_LATIN},
    '{8'hA0, 1'b0, KIND_LATIN},
    '{8'h80, 1'b0, KIND_LATIN},
    '{8'h80, 1'b0, KIND_LATIN},
    '{8'hF0, 1'b0, KIND_LATIN},
    '{8'h00, 1'b1, KIND_CJK}
  };

  codepoint_t limit_cps [0:26] = '{
    21'h00036F, 21'h000370, 21'h0004FF, 21'h000500, 21'h002FFF, 21'h003000,
    21'h0030FF, 21'h003100, 21'h004DFF, 21'h004E00, 21'h009FEF, 21'h009FF0,
    21'h00ABFF, 21'h00AC00, 21'h00D7A3, 21'h00D7A4, 21'h01FFFF, 21'h020000,
    21'h0200CC, 21'h0200CD, 21'h00007F, 21'h000080, 21'h0007FF, 21'h000800,
    21'h00FFFF, 21'h010000, 21'h1FFFFF
  };

  always #5 clk = ~clk;

  function automatic void mark_script(input codepoint_t cp);
    if (cp >= HANGUL_LO && cp <= HANGUL_HI) seen.hangul = 1'b1;
    if ((cp >= CJK_LO && cp <= CJK_HI) || (cp >= CJKB_LO && cp <= CJKB_HI)) seen.cjk = 1'b1;
    if (cp >= JAPANESE_LO && cp <= JAPANESE_HI) seen.japanese = 1'b1;
    if (cp >= GRCY_LO && cp <= GRCY_HI) seen.grcy = 1'b1;
  endfunction

  // Returns 1 when the byte closes the string, with the script kind in k.
  function automatic bit absorb_byte(input byte_t b, output kind_t k);
    k = KIND_LATIN;
    if (b == 8'h00) begin
      if (seen.hangul) begin
        k = KIND_HANGUL;
      end else if (seen.cjk) begin
        k = KIND_CJK;
      end else if (seen.japanese) begin
        k = KIND_JAPANESE;
      end else if (seen.grcy) begin
        k = KIND_GRCY;
      end
      cont_left = '0;
      cp_acc = '0;
      seen = '0;
      return 1'b1;
    end
    if (cont_left != 0) begin
      if ((b & CONT_MASK) == CONT_TAG) begin
        cp_acc = {cp_acc[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 0) begin
          mark_script(cp_acc);
          cp_acc = '0;
        end
        return 1'b0;
      end
      // A broken sequence is dropped and the failing byte starts over.
      cont_left = '0;
      cp_acc = '0;
    end
    if (b[7] == 1'b0) begin
      mark_script({13'd0, b});
    end else if (b[7:5] == 3'b110) begin
      cp_acc = {16'd0, b[4:0]};
      cont_left = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      cp_acc = {17'd0, b[3:0]};
      cont_left = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      cp_acc = {18'd0, b[2:0]};
      cont_left = 2'd3;
    end
    return 1'b0;
  endfunction

  // Drives one beat, waits for it to be taken, then, if it closes a string, records the expected result.
  task automatic feed_byte(input byte_t b, input bit typed, input kind_t typed_kind);
    kind_t k;
    bit    closes;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      text_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    text_ch.valid <= 1'b1;
    text_ch.text_byte <= b;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    bytes_sent++;
    closes = absorb_byte(b, k);
    if (closes) kind_expect_q.insert(kind_expect_q.size(), typed ? typed_kind : k);
  endtask

  task automatic send_random_text();
    int unsigned n_chars;
    int unsigned len;
    int unsigned keep;
    codepoint_t  cp;
    byte_t       enc [0:3];
    n_chars = $urandom_range(0, 6);
    repeat (n_chars) begin
      if ($urandom_range(99) < 8) begin
        feed_byte(byte_t'($urandom_range(1, 255)), 1'b0, KIND_LATIN);
      end else begin
        case ($urandom_range(7))
          0: cp = codepoint_t'($urandom_range(1, 127));
          1: cp = codepoint_t'($urandom_range(GRCY_LO, GRCY_HI));
          2: cp = codepoint_t'($urandom_range(JAPANESE_LO, JAPANESE_HI));
          3: cp = codepoint_t'($urandom_range(CJK_LO, CJK_HI));
          4: cp = codepoint_t'($urandom_range(CJKB_LO, CJKB_HI));
          5: cp = codepoint_t'($urandom_range(HANGUL_LO, HANGUL_HI));
          6: cp = limit_cps[$urandom_range(0, 26)];
          default: cp = codepoint_t'($urandom);
        endcase
        if (cp < 21'h80) len = 1;
        else if (cp < 21'h800) len = 2;
        else if (cp < 21'h10000) len = 3;
        else len = 4;
        if ($urandom_range(7) == 0) len = $urandom_range(len, 4);
        if (cp == 0 && len == 1) len = 2;
        case (len)
          1: enc[0] = {1'b0, cp[6:0]};
          2: begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
          end
          3: begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
          end
          default: begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
          end
        endcase
        keep = len;
        if (len > 1 && $urandom_range(99) < 8) keep = $urandom_range(1, len - 1);
        for (int i = 0; i < keep; i++) feed_byte(enc[i], 1'b0, KIND_LATIN);
      end
    end
    feed_byte(8'h00, 1'b0, KIND_LATIN);
  endtask

  task automatic drain_results();
    text_ch.valid <= 1'b0;
    while (kind_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    kind_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    kind_t want;
    if (!rst && kind_ch.valid && kind_ch.ready) begin
      if (kind_expect_q.size() == 0) begin
        $display("%0t: unexpected script_kind beat, expected none, actual %0d",
                 $time, kind_ch.script_kind);
        errors++;
      end else begin
        want = kind_expect_q.pop_front();
        if (kind_ch.script_kind !== want) begin
          $display("%0t: script_kind mismatch, expected %0d, actual %0d",
                   $time, want, kind_ch.script_kind);
          errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    rst = 1'b1;
    text_ch.valid = 1'b0;
    text_ch.text_byte = 8'h00;
    cont_left = '0;
    cp_acc = '0;
    seen = '0;
    errors = 0;
    bytes_sent = 0;
    gap_pct = 0;
    stall_pct = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (text_rows[i]) feed_byte(text_rows[i].b, text_rows[i].typed, text_rows[i].kind);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct = 55;
          stall_pct = 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct = 55;
        end
        default: begin
          gap_pct = 7;
          stall_pct = 7;
        end
      endcase
      while (bytes_sent < 26 + 170 * (phase + 1)) send_random_text();
      drain_results();
    end

    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
